### sv/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants of the segment pool allocator
// Field widths, status and command codes, controller/datapath handshake types.
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int OFF_W         = 20;
   localparam int LEN_W         = OFF_W + 1;
   localparam int CNT_OUT_W     = 7;
   localparam int CSR_IDX_W     = 1;
   localparam int DEF_SEGMENTS  = 64;
   localparam int DEF_GAP_SLOTS = 64;

   localparam logic [LEN_W-1:0] POOL_TOP   = LEN_W'(1) << OFF_W;
   localparam logic [LEN_W-1:0] POOL_RESET = POOL_TOP;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = CSR_IDX_W'(1);

   localparam logic FIT_FIRST = 1'b0;
   localparam logic FIT_BEST  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_INIT,
      CMD_LOAD,
      CMD_SCAN,
      CMD_READ_NEXT,
      CMD_READ_PREV,
      CMD_ALLOC_A,
      CMD_ALLOC_B,
      CMD_RELEASE,
      CMD_REJECT
   } cmd_type;

   typedef enum logic [1:0] {
      V_REJECT,
      V_ALLOC,
      V_RELEASE
   } verdict_type;

   typedef struct packed {
      cmd_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic        init_pending;
      logic        scan_done;
      verdict_type verdict;
   } dp_status_type;

endpackage

### sv/spa_req_if.sv
// ----------------------------------------------------------------------------
// spa_req_if: request channel
// Allocate or release request with valid/ready.
// ----------------------------------------------------------------------------
interface spa_req_if;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic [spa_pkg::LEN_W-1:0] request_size;
   logic [spa_pkg::OFF_W-1:0] release_offset;

   modport source (output valid, output opcode, output request_size,
                   output release_offset, input ready);
   modport sink   (input valid, input opcode, input request_size,
                   input release_offset, output ready);
endinterface

### sv/spa_rsp_if.sv
// ----------------------------------------------------------------------------
// spa_rsp_if: response channel
// One result per request with valid/ready.
// ----------------------------------------------------------------------------
interface spa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [spa_pkg::OFF_W-1:0]     granted_offset;
   logic [spa_pkg::LEN_W-1:0]     granted_size;
   logic [spa_pkg::CNT_OUT_W-1:0] active_allocs;
   logic [spa_pkg::LEN_W-1:0]     allocated_bytes;
   logic [spa_pkg::CNT_OUT_W-1:0] gap_count;

   modport source (output valid, output status, output granted_offset,
                   output granted_size, output active_allocs,
                   output allocated_bytes, output gap_count, input ready);
   modport sink   (input valid, input status, input granted_offset,
                   input granted_size, input active_allocs,
                   input allocated_bytes, input gap_count, output ready);
endinterface

### sv/spa_csr_if.sv
// ----------------------------------------------------------------------------
// spa_csr_if: configuration write channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface spa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [spa_pkg::CSR_IDX_W-1:0] index;
   logic [spa_pkg::LEN_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/spa_ctrl.sv
// ----------------------------------------------------------------------------
// spa_ctrl: request sequencer
// Steps the datapath through scan, decision and table update per request.
// ----------------------------------------------------------------------------
module spa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  spa_pkg::dp_status_type dp_status,
   output spa_pkg::dp_cmd_type    dp_cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_ALLOC_A,
      S_ALLOC_B,
      S_READ_NEXT,
      S_READ_PREV,
      S_RELEASE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      rsp_free;
   logic      emit;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      dp_cmd.op = spa_pkg::CMD_IDLE;
      req_ready = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (dp_status.init_pending) begin
               dp_cmd.op = spa_pkg::CMD_INIT;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  dp_cmd.op = spa_pkg::CMD_LOAD;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            dp_cmd.op = spa_pkg::CMD_SCAN;
            if (dp_status.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            unique case (dp_status.verdict)
               spa_pkg::V_ALLOC:   state_in = S_ALLOC_A;
               spa_pkg::V_RELEASE: state_in = S_READ_NEXT;
               spa_pkg::V_REJECT: begin
                  if (rsp_free) begin
                     dp_cmd.op = spa_pkg::CMD_REJECT;
                     emit      = 1'b1;
                     state_in  = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_ALLOC_A: begin
            dp_cmd.op = spa_pkg::CMD_ALLOC_A;
            state_in  = S_ALLOC_B;
         end
         S_ALLOC_B: begin
            if (rsp_free) begin
               dp_cmd.op = spa_pkg::CMD_ALLOC_B;
               emit      = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_READ_NEXT: begin
            dp_cmd.op = spa_pkg::CMD_READ_NEXT;
            state_in  = S_READ_PREV;
         end
         S_READ_PREV: begin
            dp_cmd.op = spa_pkg::CMD_READ_PREV;
            state_in  = S_RELEASE;
         end
         S_RELEASE: begin
            if (rsp_free) begin
               dp_cmd.op = spa_pkg::CMD_RELEASE;
               emit      = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### sv/spa_datapath.sv
// ----------------------------------------------------------------------------
// spa_datapath: segment table, flags, counters and result register
// Field memories with registered reads, one table entry examined per cycle.
// ----------------------------------------------------------------------------
module spa_datapath #(
   parameter int SEGMENTS  = spa_pkg::DEF_SEGMENTS,
   parameter int GAP_SLOTS = spa_pkg::DEF_GAP_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spa_pkg::dp_cmd_type           dp_cmd,
   output spa_pkg::dp_status_type        dp_status,
   input  logic                          req_opcode,
   input  logic [spa_pkg::LEN_W-1:0]     req_size,
   input  logic [spa_pkg::OFF_W-1:0]     req_offset,
   input  logic                          csr_write,
   input  logic [spa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spa_pkg::LEN_W-1:0]     csr_data,
   output logic [1:0]                    rsp_status,
   output logic [spa_pkg::OFF_W-1:0]     rsp_offset,
   output logic [spa_pkg::LEN_W-1:0]     rsp_size,
   output logic [spa_pkg::CNT_OUT_W-1:0] rsp_allocs,
   output logic [spa_pkg::LEN_W-1:0]     rsp_bytes,
   output logic [spa_pkg::CNT_OUT_W-1:0] rsp_gaps
);

   localparam int OW   = spa_pkg::OFF_W;
   localparam int LN   = spa_pkg::LEN_W;
   localparam int IW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int LW   = $clog2(SEGMENTS + 1);
   localparam int CW   = $clog2(SEGMENTS + 1);
   localparam int GMAX = (SEGMENTS > GAP_SLOTS) ? SEGMENTS : GAP_SLOTS;
   localparam int GW   = $clog2(GMAX + 1);
   localparam int XW   = (CW > GW ? CW : GW) + spa_pkg::CNT_OUT_W;
   localparam logic [LW-1:0] NONE = LW'(SEGMENTS);

   typedef logic [1:0] status_sel_type;

   // field memories
   logic [OW-1:0] off_mem  [SEGMENTS];
   logic [LN-1:0] len_mem  [SEGMENTS];
   logic [LW-1:0] next_mem [SEGMENTS];
   logic [LW-1:0] prev_mem [SEGMENTS];

   logic          off_we, len_we, next_we, prev_we;
   logic [IW-1:0] off_wa, len_wa, next_wa, prev_wa;
   logic [OW-1:0] off_wd;
   logic [LN-1:0] len_wd;
   logic [LW-1:0] next_wd, prev_wd;
   logic [IW-1:0] rd_addr;

   logic [OW-1:0] rd_off_ff;
   logic [LN-1:0] rd_len_ff;
   logic [LW-1:0] rd_next_ff, rd_prev_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          rd_live_ff;

   // flags and counters
   logic [SEGMENTS-1:0] in_use_ff, alloc_ff;
   logic [GW-1:0]       gaps_ff, gaps_in;
   logic [CW-1:0]       segs_ff, segs_in, allocs_ff, allocs_in;
   logic [LN-1:0]       bytes_ff, bytes_in;
   logic                init_pend_ff;
   logic [LN-1:0]       pool_ff;
   logic                policy_ff;

   // request and scan capture
   logic          op_ff;
   logic [LN-1:0] size_ff;
   logic [OW-1:0] roff_ff;
   logic [LW-1:0] scan_cnt_ff;
   logic          found_ff, spare_found_ff;
   logic [IW-1:0] cap_idx_ff, spare_ff;
   logic [OW-1:0] cap_off_ff;
   logic [LN-1:0] cap_len_ff;
   logic [LW-1:0] cap_next_ff, cap_prev_ff;
   logic [LN-1:0] nx_len_ff;
   logic [LW-1:0] nx_next_ff;

   logic                 r_use, r_alloc, fit_ok, better, rel_ok, take, spare_take;
   logic                 nx_live, pv_live, nf, pf, split;
   logic [LN-1:0]        rest, total, pool_clamp;
   logic [LW-1:0]        nn;
   logic [IW-1:0]        tgt;
   status_sel_type       st_sel;
   spa_pkg::verdict_type verdict;
   logic                 final_load;

   // scan evaluation on the registered read
   assign r_use   = in_use_ff[rd_idx_ff];
   assign r_alloc = alloc_ff[rd_idx_ff];
   assign fit_ok  = r_use && !r_alloc && (rd_len_ff >= size_ff);
   assign better  = (policy_ff == spa_pkg::FIT_FIRST) ? !found_ff :
                    (!found_ff || (rd_len_ff < cap_len_ff) ||
                     ((rd_len_ff == cap_len_ff) && (rd_off_ff < cap_off_ff)));
   assign rel_ok  = r_use && r_alloc && (rd_off_ff == roff_ff) && !found_ff;
   assign take    = rd_live_ff && ((op_ff == spa_pkg::OP_RELEASE) ? rel_ok :
                                   (fit_ok && better));
   assign spare_take = rd_live_ff && !r_use && !spare_found_ff;

   assign nx_live = cap_next_ff < NONE;
   assign pv_live = cap_prev_ff < NONE;
   assign nf = nx_live && in_use_ff[cap_next_ff[IW-1:0]] && !alloc_ff[cap_next_ff[IW-1:0]];
   assign pf = pv_live && in_use_ff[cap_prev_ff[IW-1:0]] && !alloc_ff[cap_prev_ff[IW-1:0]];

   assign rest  = cap_len_ff - size_ff;
   assign split = (rest != '0) && spare_found_ff;
   assign total = cap_len_ff + (nf ? nx_len_ff : '0) + (pf ? rd_len_ff : '0);
   assign nn    = nf ? nx_next_ff : cap_next_ff;
   assign tgt   = pf ? cap_prev_ff[IW-1:0] : cap_idx_ff;

   assign pool_clamp = (csr_data == '0) ? LN'(1) :
                       ((csr_data > spa_pkg::POOL_TOP) ? spa_pkg::POOL_TOP : csr_data);

   assign dp_status.init_pending = init_pend_ff;
   assign dp_status.scan_done    = rd_live_ff && (rd_idx_ff == IW'(SEGMENTS - 1));
   assign dp_status.verdict      = verdict;

   // decision after the scan
   always_comb begin
      verdict = spa_pkg::V_REJECT;
      st_sel  = spa_pkg::ST_NO_FIT;
      if (op_ff == spa_pkg::OP_ALLOC) begin
         priority if ((size_ff == '0) || (gaps_ff == '0)) begin
            st_sel = spa_pkg::ST_NO_FIT;
         end else if (segs_ff >= CW'(SEGMENTS)) begin
            st_sel = spa_pkg::ST_FULL;
         end else if (!found_ff) begin
            st_sel = spa_pkg::ST_NO_FIT;
         end else begin
            st_sel  = spa_pkg::ST_OK;
            verdict = spa_pkg::V_ALLOC;
         end
      end else begin
         priority if (!found_ff) begin
            st_sel = spa_pkg::ST_NOT_FOUND;
         end else if (!nf && !pf && (gaps_ff >= GW'(GAP_SLOTS))) begin
            st_sel = spa_pkg::ST_FULL;
         end else begin
            st_sel  = spa_pkg::ST_OK;
            verdict = spa_pkg::V_RELEASE;
         end
      end
   end

   // read address
   always_comb begin
      priority case (dp_cmd.op)
         spa_pkg::CMD_SCAN:      rd_addr = scan_cnt_ff[IW-1:0];
         spa_pkg::CMD_READ_NEXT: rd_addr = cap_next_ff[IW-1:0];
         default:                rd_addr = cap_prev_ff[IW-1:0];
      endcase
   end

   // write ports
   always_comb begin
      off_we  = 1'b0; off_wa  = cap_idx_ff; off_wd  = '0;
      len_we  = 1'b0; len_wa  = cap_idx_ff; len_wd  = '0;
      next_we = 1'b0; next_wa = cap_idx_ff; next_wd = NONE;
      prev_we = 1'b0; prev_wa = cap_idx_ff; prev_wd = NONE;
      unique case (dp_cmd.op)
         spa_pkg::CMD_INIT: begin
            off_we  = 1'b1; off_wa  = '0;
            len_we  = 1'b1; len_wa  = '0; len_wd = pool_ff;
            next_we = 1'b1; next_wa = '0;
            prev_we = 1'b1; prev_wa = '0;
         end
         spa_pkg::CMD_ALLOC_A: begin
            len_we = 1'b1;
            len_wd = size_ff;
            if (split) begin
               off_we  = 1'b1; off_wa  = spare_ff;
               off_wd  = cap_off_ff + size_ff[OW-1:0];
               prev_we = 1'b1; prev_wa = spare_ff; prev_wd = LW'(cap_idx_ff);
               next_we = 1'b1; next_wa = spare_ff; next_wd = cap_next_ff;
            end
         end
         spa_pkg::CMD_ALLOC_B: begin
            if (split) begin
               len_we  = 1'b1; len_wa = spare_ff; len_wd = rest;
               next_we = 1'b1; next_wd = LW'(spare_ff);
               if (nx_live) begin
                  prev_we = 1'b1; prev_wa = cap_next_ff[IW-1:0];
                  prev_wd = LW'(spare_ff);
               end
            end
         end
         spa_pkg::CMD_RELEASE: begin
            len_we  = 1'b1; len_wa  = tgt; len_wd  = total;
            next_we = 1'b1; next_wa = tgt; next_wd = nn;
            if (nn < NONE) begin
               prev_we = 1'b1; prev_wa = nn[IW-1:0]; prev_wd = LW'(tgt);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (off_we)  off_mem[off_wa]   <= off_wd;
      if (len_we)  len_mem[len_wa]   <= len_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      rd_off_ff  <= off_mem[rd_addr];
      rd_len_ff  <= len_mem[rd_addr];
      rd_next_ff <= next_mem[rd_addr];
      rd_prev_ff <= prev_mem[rd_addr];
   end

   // counter updates
   always_comb begin
      gaps_in   = gaps_ff;
      segs_in   = segs_ff;
      allocs_in = allocs_ff;
      bytes_in  = bytes_ff;
      unique case (dp_cmd.op)
         spa_pkg::CMD_INIT: begin
            gaps_in   = GW'(1);
            segs_in   = CW'(1);
            allocs_in = '0;
            bytes_in  = '0;
         end
         spa_pkg::CMD_ALLOC_B: begin
            allocs_in = allocs_ff + CW'(1);
            bytes_in  = bytes_ff + size_ff;
            if (split) begin
               segs_in = segs_ff + CW'(1);
            end else begin
               gaps_in = gaps_ff - GW'(1);
            end
         end
         spa_pkg::CMD_RELEASE: begin
            allocs_in = (allocs_ff != '0) ? allocs_ff - CW'(1) : allocs_ff;
            bytes_in  = (bytes_ff >= cap_len_ff) ? bytes_ff - cap_len_ff : '0;
            segs_in   = segs_ff - CW'(nf) - CW'(pf);
            gaps_in   = gaps_ff + GW'(1) - GW'(nf) - GW'(pf);
         end
         default: ;
      endcase
   end

   assign final_load = (dp_cmd.op == spa_pkg::CMD_REJECT) ||
                       (dp_cmd.op == spa_pkg::CMD_ALLOC_B) ||
                       (dp_cmd.op == spa_pkg::CMD_RELEASE);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff      <= SEGMENTS'(1);
         alloc_ff       <= '0;
         gaps_ff        <= GW'(1);
         segs_ff        <= CW'(1);
         allocs_ff      <= '0;
         bytes_ff       <= '0;
         init_pend_ff   <= 1'b1;
         pool_ff        <= spa_pkg::POOL_RESET;
         policy_ff      <= spa_pkg::FIT_FIRST;
         rd_live_ff     <= 1'b0;
         scan_cnt_ff    <= '0;
         found_ff       <= 1'b0;
         spare_found_ff <= 1'b0;
      end else begin
         gaps_ff   <= gaps_in;
         segs_ff   <= segs_in;
         allocs_ff <= allocs_in;
         bytes_ff  <= bytes_in;
         rd_live_ff <= 1'b0;
         if (take)       found_ff       <= 1'b1;
         if (spare_take) spare_found_ff <= 1'b1;
         unique case (dp_cmd.op)
            spa_pkg::CMD_INIT: begin
               in_use_ff <= SEGMENTS'(1);
               alloc_ff  <= '0;
            end
            spa_pkg::CMD_LOAD: begin
               scan_cnt_ff    <= '0;
               found_ff       <= 1'b0;
               spare_found_ff <= 1'b0;
            end
            spa_pkg::CMD_SCAN: begin
               if (scan_cnt_ff < NONE) begin
                  scan_cnt_ff <= scan_cnt_ff + LW'(1);
                  rd_live_ff  <= 1'b1;
               end
            end
            spa_pkg::CMD_ALLOC_A: begin
               alloc_ff[cap_idx_ff] <= 1'b1;
               if (split) begin
                  in_use_ff[spare_ff] <= 1'b1;
                  alloc_ff[spare_ff]  <= 1'b0;
               end
            end
            spa_pkg::CMD_RELEASE: begin
               alloc_ff[cap_idx_ff] <= 1'b0;
               if (nf) in_use_ff[cap_next_ff[IW-1:0]] <= 1'b0;
               if (pf) in_use_ff[cap_idx_ff] <= 1'b0;
            end
            default: ;
         endcase
         // a pool size write restarts the pool on the next idle cycle
         if (csr_write && (csr_index == spa_pkg::CSR_POOL_SIZE)) begin
            init_pend_ff <= 1'b1;
         end else if (dp_cmd.op == spa_pkg::CMD_INIT) begin
            init_pend_ff <= 1'b0;
         end
         if (csr_write) begin
            if (csr_index == spa_pkg::CSR_POOL_SIZE) begin
               pool_ff <= pool_clamp;
            end else if (csr_index == spa_pkg::CSR_FIT_POLICY) begin
               policy_ff <= csr_data[0];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_cnt_ff[IW-1:0];
      if (dp_cmd.op == spa_pkg::CMD_LOAD) begin
         op_ff   <= req_opcode;
         size_ff <= req_size;
         roff_ff <= req_offset;
      end
      if (take) begin
         cap_idx_ff  <= rd_idx_ff;
         cap_off_ff  <= rd_off_ff;
         cap_len_ff  <= rd_len_ff;
         cap_next_ff <= rd_next_ff;
         cap_prev_ff <= rd_prev_ff;
      end
      if (spare_take) spare_ff <= rd_idx_ff;
      if (dp_cmd.op == spa_pkg::CMD_READ_PREV) begin
         nx_len_ff  <= rd_len_ff;
         nx_next_ff <= rd_next_ff;
      end
      if (final_load) begin
         rsp_status <= (dp_cmd.op == spa_pkg::CMD_REJECT) ? st_sel : spa_pkg::ST_OK;
         rsp_offset <= (dp_cmd.op == spa_pkg::CMD_ALLOC_B) ? cap_off_ff : '0;
         rsp_size   <= (dp_cmd.op == spa_pkg::CMD_ALLOC_B) ? size_ff :
                       ((dp_cmd.op == spa_pkg::CMD_RELEASE) ? cap_len_ff : '0);
         rsp_allocs <= spa_pkg::CNT_OUT_W'(XW'(allocs_in));
         rsp_bytes  <= bytes_in;
         rsp_gaps   <= spa_pkg::CNT_OUT_W'(XW'(gaps_in));
      end
   end

endmodule

### sv/segment_pool_allocator.sv
// ----------------------------------------------------------------------------
// segment_pool_allocator: pool allocator with first/best fit and coalescing
//
//   channel  direction  transfer when        carries
//   req      in         valid & ready        opcode, request_size, release_offset
//   rsp      out        valid & ready        status, grant, counters
//   csr      in         valid (ready high)   index, data
//
// A request scans the table, one entry examined per cycle through the registered read
// of the segment field memories; then a reject answers from the decision step, an
// allocate runs two update steps and a release reads both neighbours, then updates.
// After reset and after each pool size write a restart step runs when the sequencer
// is next idle, before it takes another request. A held response stalls only the
// final step; the next request is taken while the response waits.
// ----------------------------------------------------------------------------
module segment_pool_allocator #(
   parameter int SEGMENTS  = spa_pkg::DEF_SEGMENTS,
   parameter int GAP_SLOTS = spa_pkg::DEF_GAP_SLOTS
) (
   input logic        clock,
   input logic        reset,
   spa_req_if.sink    req_chan,
   spa_rsp_if.source  rsp_chan,
   spa_csr_if.sink    csr_chan
);

   spa_pkg::dp_cmd_type    dp_cmd;
   spa_pkg::dp_status_type dp_status;

   assign csr_chan.ready = 1'b1;

   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   spa_datapath #(
      .SEGMENTS  (SEGMENTS),
      .GAP_SLOTS (GAP_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .req_opcode (req_chan.opcode),
      .req_size   (req_chan.request_size),
      .req_offset (req_chan.release_offset),
      .csr_write  (csr_chan.valid),
      .csr_index  (csr_chan.index),
      .csr_data   (csr_chan.data),
      .rsp_status (rsp_chan.status),
      .rsp_offset (rsp_chan.granted_offset),
      .rsp_size   (rsp_chan.granted_size),
      .rsp_allocs (rsp_chan.active_allocs),
      .rsp_bytes  (rsp_chan.allocated_bytes),
      .rsp_gaps   (rsp_chan.gap_count)
   );

endmodule

### sim/segment_pool_allocator_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared helpers for the allocator bench
// Request and reply item types used by the stimulus and expected-reply queues and the predictor.
// ----------------------------------------------------------------------------
package spa_tb_pkg;

   typedef struct packed {
      logic                      opcode;
      logic [spa_pkg::LEN_W-1:0] request_size;
      logic [spa_pkg::OFF_W-1:0] release_offset;
   } pool_request_type;

   typedef struct packed {
      spa_pkg::status_type           status;
      logic [spa_pkg::OFF_W-1:0]     granted_offset;
      logic [spa_pkg::LEN_W-1:0]     granted_size;
      logic [spa_pkg::CNT_OUT_W-1:0] active_allocs;
      logic [spa_pkg::LEN_W-1:0]     allocated_bytes;
      logic [spa_pkg::CNT_OUT_W-1:0] gap_count;
   } pool_reply_type;
endpackage

### sim/segment_pool_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_pool_allocator_tb: self-checking bench of the segment pool allocator
// Drives allocate/release requests under random stalls, predicts each reply
// with a behavioral segment table model, and compares replies in order.
// ----------------------------------------------------------------------------
module segment_pool_allocator_tb;

   localparam int OFF_W     = spa_pkg::OFF_W;
   localparam int LEN_W     = spa_pkg::LEN_W;
   localparam int CNT_OUT_W = spa_pkg::CNT_OUT_W;
   localparam int CSR_IDX_W = spa_pkg::CSR_IDX_W;
   localparam int NSEG      = spa_pkg::DEF_SEGMENTS;
   localparam int NGAP      = spa_pkg::DEF_GAP_SLOTS;
   localparam int NO_LINK   = NSEG;
   localparam int WATCHDOG  = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spa_req_if req_chan ();
   spa_rsp_if rsp_chan ();
   spa_csr_if csr_chan ();

   segment_pool_allocator u_top (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [OFF_W-1:0] m_off   [NSEG];
   logic [LEN_W-1:0] m_len   [NSEG];
   bit               m_alloc [NSEG];
   bit               m_used  [NSEG];
   int               m_next  [NSEG];
   int               m_prev  [NSEG];
   int               m_gaps  [NGAP];
   int               m_gaps_held, m_segs_used, m_allocs;
   logic [LEN_W-1:0] m_bytes, m_pool;
   logic             m_policy;

   spa_tb_pkg::pool_request_type pending_reqs[$];
   spa_tb_pkg::pool_reply_type   expected_replies[$];
   int  mismatches = 0, replies_seen = 0, ok_replies = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0, hold_rsp = 1'b0;

   function automatic void clear_seg(int s);
      m_off[s] = '0; m_len[s] = '0; m_alloc[s] = 0; m_used[s] = 0;
      m_next[s] = NO_LINK; m_prev[s] = NO_LINK;
   endfunction

   function automatic void restart_pool(logic [LEN_W-1:0] size);
      if (size == '0) size = LEN_W'(1);
      if (size > spa_pkg::POOL_TOP) size = spa_pkg::POOL_TOP;
      m_pool = size;
      for (int i = 0; i < NSEG; i++) clear_seg(i);
      for (int i = 0; i < NGAP; i++) m_gaps[i] = 0;
      m_len[0] = size; m_used[0] = 1;
      m_gaps_held = 1; m_segs_used = 1; m_allocs = 0; m_bytes = '0;
   endfunction

   function automatic bit sorts_first(int a, int b);
      if (m_len[a] != m_len[b]) return m_len[a] < m_len[b];
      return m_off[a] < m_off[b];
   endfunction

   function automatic void gap_insert(int s);
      int t;
      if (m_gaps_held >= NGAP) return;
      m_gaps[m_gaps_held] = s;
      m_gaps_held++;
      for (int i = m_gaps_held - 1; i > 0; i--)
         if (sorts_first(m_gaps[i], m_gaps[i-1])) begin
            t = m_gaps[i-1]; m_gaps[i-1] = m_gaps[i]; m_gaps[i] = t;
         end
   endfunction

   function automatic void gap_drop(int s);
      int pos;
      pos = m_gaps_held;
      for (int i = 0; i < m_gaps_held; i++)
         if (m_gaps[i] == s) begin
            pos = i;
            break;
         end
      if (pos >= m_gaps_held) return;
      for (int i = pos; i + 1 < m_gaps_held; i++) m_gaps[i] = m_gaps[i+1];
      m_gaps_held--;
      m_gaps[m_gaps_held] = 0;
   endfunction

   function automatic bit is_gap(int s);
      return s < NSEG && m_used[s] && !m_alloc[s];
   endfunction

   function automatic spa_tb_pkg::pool_reply_type predict_reply(
      spa_tb_pkg::pool_request_type rq);
      spa_tb_pkg::pool_reply_type r;
      int pick, spare, cur, nx, pv, nn;
      bit nf, pf;
      logic [LEN_W-1:0] rest;
      r = '0;
      r.status = spa_pkg::ST_OK;
      if (rq.opcode == spa_pkg::OP_ALLOC) begin
         pick = NO_LINK;
         if (rq.request_size == '0 || m_gaps_held == 0) r.status = spa_pkg::ST_NO_FIT;
         else if (m_segs_used >= NSEG) r.status = spa_pkg::ST_FULL;
         else begin
            if (m_policy == spa_pkg::FIT_FIRST) begin
               for (int i = 0; i < NSEG; i++)
                  if (is_gap(i) && m_len[i] >= rq.request_size) begin
                     pick = i;
                     break;
                  end
            end else begin
               for (int i = 0; i < m_gaps_held; i++)
                  if (is_gap(m_gaps[i]) && m_len[m_gaps[i]] >= rq.request_size) begin
                     pick = m_gaps[i];
                     break;
                  end
            end
            if (pick >= NSEG) r.status = spa_pkg::ST_NO_FIT;
         end
         if (r.status == spa_pkg::ST_OK) begin
            rest = m_len[pick] - rq.request_size;
            m_allocs++;
            m_bytes += rq.request_size;
            gap_drop(pick);
            m_alloc[pick] = 1;
            m_len[pick] = rq.request_size;
            if (rest != '0) begin
               spare = NO_LINK;
               for (int i = 0; i < NSEG; i++)
                  if (!m_used[i]) begin
                     spare = i;
                     break;
                  end
               if (spare < NSEG) begin
                  m_used[spare] = 1; m_alloc[spare] = 0;
                  m_off[spare] = m_off[pick] + rq.request_size[OFF_W-1:0];
                  m_len[spare] = rest;
                  m_segs_used++;
                  nx = m_next[pick];
                  m_prev[spare] = pick; m_next[spare] = nx;
                  if (nx < NSEG) m_prev[nx] = spare;
                  m_next[pick] = spare;
                  gap_insert(spare);
               end
            end
            r.granted_offset = m_off[pick];
            r.granted_size = rq.request_size;
         end
      end else begin
         cur = NO_LINK;
         for (int i = 0; i < NSEG; i++)
            if (m_used[i] && m_alloc[i] && m_off[i] == rq.release_offset) begin
               cur = i;
               break;
            end
         if (cur >= NSEG) r.status = spa_pkg::ST_NOT_FOUND;
         else begin
            nf = is_gap(m_next[cur]);
            pf = is_gap(m_prev[cur]);
            if (!nf && !pf && m_gaps_held >= NGAP) r.status = spa_pkg::ST_FULL;
            else begin
               r.granted_size = m_len[cur];
               m_alloc[cur] = 0;
               if (m_allocs > 0) m_allocs--;
               m_bytes = (m_bytes >= m_len[cur]) ? m_bytes - m_len[cur] : '0;
               if (nf) begin
                  nx = m_next[cur];
                  gap_drop(nx);
                  m_len[cur] += m_len[nx];
                  nn = m_next[nx];
                  m_next[cur] = nn;
                  if (nn < NSEG) m_prev[nn] = cur;
                  clear_seg(nx);
                  m_segs_used--;
               end
               if (pf) begin
                  pv = m_prev[cur];
                  gap_drop(pv);
                  m_len[pv] += m_len[cur];
                  nn = m_next[cur];
                  m_next[pv] = nn;
                  if (nn < NSEG) m_prev[nn] = pv;
                  clear_seg(cur);
                  m_segs_used--;
                  cur = pv;
               end
               gap_insert(cur);
            end
         end
      end
      r.active_allocs = m_allocs[CNT_OUT_W-1:0];
      r.allocated_bytes = m_bytes;
      r.gap_count = m_gaps_held[CNT_OUT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("MISMATCH reply %0d %s: got %0h want %0h", replies_seen, what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
            req_chan.valid          <= 1'b1;
            req_chan.opcode         <= pending_reqs[0].opcode;
            req_chan.request_size   <= pending_reqs[0].request_size;
            req_chan.release_offset <= pending_reqs[0].release_offset;
            expected_replies.push_back(predict_reply(pending_reqs.pop_front()));
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      spa_tb_pkg::pool_reply_type w;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected", 32'd1, 32'd0);
            end else begin
               w = expected_replies.pop_front();
               if (rsp_chan.status !== w.status)
                  report_mismatch("status", 32'(rsp_chan.status), 32'(w.status));
               if (rsp_chan.granted_offset !== w.granted_offset)
                  report_mismatch("granted_offset", 32'(rsp_chan.granted_offset),
                                  32'(w.granted_offset));
               if (rsp_chan.granted_size !== w.granted_size)
                  report_mismatch("granted_size", 32'(rsp_chan.granted_size),
                                  32'(w.granted_size));
               if (rsp_chan.active_allocs !== w.active_allocs)
                  report_mismatch("active_allocs", 32'(rsp_chan.active_allocs),
                                  32'(w.active_allocs));
               if (rsp_chan.allocated_bytes !== w.allocated_bytes)
                  report_mismatch("allocated_bytes", 32'(rsp_chan.allocated_bytes),
                                  32'(w.allocated_bytes));
               if (rsp_chan.gap_count !== w.gap_count)
                  report_mismatch("gap_count", 32'(rsp_chan.gap_count), 32'(w.gap_count));
               if (w.status == spa_pkg::ST_OK) ok_replies++;
            end
         end
         rsp_chan.ready <= !hold_rsp && (calm || $urandom_range(99) >= 7);
      end
   end

   // watchdog: count cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired, %0d replies outstanding", expected_replies.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == spa_pkg::CSR_POOL_SIZE) restart_pool(value);
      else m_policy = value[0];
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_replies.size() != 0 || req_chan.valid)
         @(posedge clock);
      repeat (3 * NSEG) @(posedge clock);
   endtask

   function automatic void push_alloc(logic [LEN_W-1:0] size);
      pending_reqs.push_back('{spa_pkg::OP_ALLOC, size, OFF_W'($urandom())});
   endfunction

   function automatic void push_release(logic [OFF_W-1:0] offset);
      pending_reqs.push_back('{spa_pkg::OP_RELEASE, LEN_W'($urandom()), offset});
   endfunction

   // pick a size scaled to the pool, mostly small
   function automatic logic [LEN_W-1:0] rand_size(logic [LEN_W-1:0] pool);
      int r;
      r = $urandom_range(99);
      if (r < 3) return '0;
      if (r < 6) return pool;
      if (r < 9) return LEN_W'($urandom_range(spa_pkg::POOL_TOP));
      if (pool < LEN_W'(64)) return LEN_W'($urandom_range(pool));
      return LEN_W'($urandom_range(pool / 16 + 1, 1));
   endfunction

   // mimic offsets the block would grant: walk a simple shadow of its own replies
   task automatic random_phase(int count, logic [LEN_W-1:0] pool);
      logic [OFF_W-1:0] o;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 55) push_alloc(rand_size(pool));
         else begin
            // release offsets are mostly taken from the predictor's live blocks, else random
            o = OFF_W'($urandom());
            if ($urandom_range(99) < 85) begin
               int k, n;
               n = 0;
               for (int s = 0; s < NSEG; s++) if (m_used[s] && m_alloc[s]) n++;
               if (n != 0) begin
                  k = $urandom_range(n - 1);
                  for (int s = 0; s < NSEG; s++)
                     if (m_used[s] && m_alloc[s]) begin
                        if (k == 0) o = m_off[s];
                        k--;
                     end
               end
            end
            push_release(o);
         end
         // keep the queue short so live offsets track the predictor
         while (pending_reqs.size() > 2) @(posedge clock);
      end
   endtask

   initial begin
      req_chan.valid = 1'b0; req_chan.opcode = spa_pkg::OP_ALLOC;
      req_chan.request_size = '0; req_chan.release_offset = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0; csr_chan.index = spa_pkg::CSR_POOL_SIZE; csr_chan.data = '0;
      m_policy = spa_pkg::FIT_FIRST;
      restart_pool(spa_pkg::POOL_RESET);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, refusals, merge on both sides
      push_alloc('0);
      push_alloc(spa_pkg::POOL_TOP);
      push_release('0);
      push_release(20'hFFFFF);
      push_alloc(spa_pkg::POOL_TOP);
      push_alloc(21'h1FFFFF);
      push_release('0);
      push_alloc(LEN_W'(16)); push_alloc(LEN_W'(32)); push_alloc(LEN_W'(48));
      push_release(OFF_W'(16)); push_release(OFF_W'(48)); push_release('0);
      push_release(OFF_W'(16));
      push_alloc(LEN_W'(1));
      drain();

      write_csr(spa_pkg::CSR_FIT_POLICY, LEN_W'(spa_pkg::FIT_BEST));
      write_csr(spa_pkg::CSR_POOL_SIZE, '0);
      push_alloc(LEN_W'(1)); push_alloc(LEN_W'(1)); push_release('0);
      push_alloc(LEN_W'(1));
      drain();

      // fill the table with tiny blocks, then release alternates for gap pressure
      write_csr(spa_pkg::CSR_POOL_SIZE, 21'h1FFFFF);
      for (int i = 0; i < 66; i++) push_alloc(LEN_W'(1));
      for (int i = 0; i < 64; i += 2) push_release(OFF_W'(i));
      push_alloc(LEN_W'(2));
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
      drain();

      // random phases across policies and pool sizes
      calm = 1'b1;
      write_csr(spa_pkg::CSR_FIT_POLICY, LEN_W'(spa_pkg::FIT_FIRST));
      write_csr(spa_pkg::CSR_POOL_SIZE, LEN_W'(4096));
      random_phase(200, LEN_W'(4096));
      calm = 1'b0;
      drain();
      write_csr(spa_pkg::CSR_FIT_POLICY, LEN_W'(spa_pkg::FIT_BEST));
      random_phase(250, LEN_W'(4096));
      drain();
      write_csr(spa_pkg::CSR_POOL_SIZE, LEN_W'(100));
      random_phase(250, LEN_W'(100));
      drain();
      write_csr(spa_pkg::CSR_FIT_POLICY, LEN_W'(spa_pkg::FIT_FIRST));
      write_csr(spa_pkg::CSR_POOL_SIZE, spa_pkg::POOL_TOP);
      random_phase(250, spa_pkg::POOL_TOP);
      drain();
      write_csr(spa_pkg::CSR_POOL_SIZE, LEN_W'($urandom_range(spa_pkg::POOL_TOP, 1)));
      random_phase(100, m_pool);
      drain();

      $display("ran %0d replies (%0d granted) over first and best fit, pool sizes 1 to full",
               replies_seen, ok_replies);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
